[rtl/chr_pkg.sv]
// Shared constants and types for the command history ring.
// Used by the top level; depends on nothing.
package chr_pkg;

   // Store size in bytes; must be a power of two so that pointers wrap freely.
   localparam int RING_SIZE   = 1024;
   localparam int PTR_W       = $clog2(RING_SIZE);
   localparam int MAX_CMD_LEN = 63;
   localparam int CNT_W       = $clog2(MAX_CMD_LEN + 1);
   localparam int SEQ_W       = CNT_W + 1;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_COMMIT = 2'd1,
      ACT_PREV   = 2'd2,
      ACT_NEXT   = 2'd3
   } action_type;

   typedef logic [PTR_W-1:0] ptr_type;

endpackage

[rtl/chr_req_if.sv]
// Request channel of the command history ring: valid/ready plus the request fields.
// Depends on chr_pkg only through the convention of the action codes.
interface chr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

[rtl/chr_rsp_if.sv]
// Response channel of the command history ring: valid/ready plus one recalled byte with found and last flags.
// Stands alone; no package is needed.
interface chr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       found;
   logic       last;

   modport source (output valid, output out_byte, output found, output last, input ready);
   modport sink   (input valid, input out_byte, input found, input last, output ready);
endinterface

[rtl/command_history_ring.sv]
// Command history ring: a sequencer drives one pointer adder over a 1024-byte store.
// Append stores one pending byte; a non-empty commit compares the pending command with
// the newest record and, when they differ, writes it as length, bytes, length; recall
// gives the record one byte a cycle while the sink takes them, or a not-found result.
// Synchronous reset; the S_INIT0 and S_INIT1 states after reset write the
// empty sentinel record at bytes 0 and 1, and no request is taken until that is done.
module command_history_ring (
   input  logic      clock,
   input  logic      reset,
   chr_req_if.sink   req_chan,
   chr_rsp_if.source rsp_chan
);
   import chr_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [14:0] {
      S_INIT0  = 15'b000000000000001,
      S_INIT1  = 15'b000000000000010,
      S_IDLE   = 15'b000000000000100,
      S_C_LEN  = 15'b000000000001000,
      S_C_CHK  = 15'b000000000010000,
      S_C_CMP  = 15'b000000000100000,
      S_W_PREP = 15'b000000001000000,
      S_W_DO   = 15'b000000010000000,
      S_P_A    = 15'b000000100000000,
      S_P_B    = 15'b000001000000000,
      S_N_A    = 15'b000010000000000,
      S_N_B    = 15'b000100000000000,
      S_E_LEN  = 15'b001000000000000,
      S_E_BYTE = 15'b010000000000000,
      S_NF     = 15'b100000000000000
   } state_type;

   // The byte store and the pending command buffer. Both have registered reads.
   logic [7:0] ring_mem [RING_SIZE];
   logic [7:0] pend_mem [MAX_CMD_LEN];

   state_type        state_ff, state_in;
   ptr_type          oldest_ff, oldest_in;
   ptr_type          cursor_ff, cursor_in;
   ptr_type          free_ff, free_in;
   ptr_type          ptr_ff, ptr_in;
   logic             after_next_ff, after_next_in;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [SEQ_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       ring_rd_ff;
   logic [7:0]       pend_rd_ff;

   logic             out_valid_ff;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             found_ff, found_in;
   logic             last_ff, last_in;
   logic             out_load;
   logic             out_free;

   logic             ring_re, ring_we;
   ptr_type          ring_raddr, ring_waddr;
   logic [7:0]       ring_wdata;
   logic             pend_re, pend_we;
   logic [CNT_W-1:0] pend_raddr;

   // The shared pointer adder. Walking backwards, the read address is one below the
   // record start, so the previous start is that address minus the length minus one,
   // which is the address plus the inverted length. Walking forwards it adds length+2.
   ptr_type          step_base;
   logic             step_fwd;
   ptr_type          off_fwd, off_back, step_sum;
   ptr_type          step_sum_dec;

   ptr_type          free_dec, cursor_dec, ptr_inc, free_inc;
   logic [SEQ_W-1:0] cnt_next, cnt_dec, pcount_ext, pcount_end, len_ext;
   logic [7:0]       pcount_byte;
   logic             evict;

   assign off_fwd      = {{(PTR_W-8){1'b0}}, ring_rd_ff} + PTR_W'(2);
   assign off_back     = ~{{(PTR_W-8){1'b0}}, ring_rd_ff};
   assign step_sum     = step_base + (step_fwd ? off_fwd : off_back);
   assign step_sum_dec = step_sum - PTR_W'(1);

   assign free_dec    = free_ff - PTR_W'(1);
   assign free_inc    = free_ff + PTR_W'(1);
   assign cursor_dec  = cursor_ff - PTR_W'(1);
   assign ptr_inc     = ptr_ff + PTR_W'(1);
   assign cnt_next    = cnt_ff + SEQ_W'(1);
   assign cnt_dec     = cnt_ff - SEQ_W'(1);
   assign pcount_ext  = {1'b0, pcount_ff};
   assign pcount_end  = pcount_ext + SEQ_W'(1);
   assign len_ext     = {1'b0, len_ff};
   assign pcount_byte = {{(8-CNT_W){1'b0}}, pcount_ff};
   // The writer has caught up with the oldest record, which must go first.
   assign evict       = (free_ff == oldest_ff);

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      cursor_in     = cursor_ff;
      free_in       = free_ff;
      ptr_in        = ptr_ff;
      after_next_in = after_next_ff;
      pcount_in     = pcount_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      ring_re       = 1'b0;
      ring_raddr    = ptr_ff;
      ring_we       = 1'b0;
      ring_waddr    = free_ff;
      ring_wdata    = 8'd0;
      pend_re       = 1'b0;
      pend_we       = 1'b0;
      pend_raddr    = cnt_ff[CNT_W-1:0];
      out_load      = 1'b0;
      out_byte_in   = 8'd0;
      found_in      = 1'b0;
      last_in       = 1'b0;
      step_base     = ptr_ff;
      step_fwd      = 1'b0;

      case (state_ff)
         S_INIT0: begin
            ring_we    = 1'b1;
            ring_waddr = '0;
            state_in   = S_INIT1;
         end
         S_INIT1: begin
            ring_we    = 1'b1;
            ring_waddr = PTR_W'(1);
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               case (action_type'(req_chan.action))
                  ACT_APPEND: begin
                     // Bytes beyond the maximum command length are dropped.
                     if (pcount_ff != CNT_W'(MAX_CMD_LEN)) begin
                        pend_we   = 1'b1;
                        pcount_in = pcount_ff + CNT_W'(1);
                     end
                  end
                  ACT_COMMIT: begin
                     after_next_in = 1'b0;
                     ring_re       = 1'b1;
                     ring_raddr    = free_dec;
                     ptr_in        = free_dec;
                     state_in      = S_C_LEN;
                  end
                  ACT_PREV: begin
                     if (cursor_ff == oldest_ff) begin
                        after_next_in = 1'b1;
                        state_in      = S_NF;
                     end else begin
                        ring_re    = 1'b1;
                        ring_raddr = cursor_dec;
                        ptr_in     = cursor_dec;
                        state_in   = S_P_A;
                     end
                  end
                  ACT_NEXT: begin
                     ring_re    = 1'b1;
                     ring_raddr = cursor_ff;
                     state_in   = S_N_A;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_C_LEN: begin
            // The cursor always moves to the newest record on a commit.
            cursor_in = step_sum;
            if (pcount_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               ring_re    = 1'b1;
               ring_raddr = step_sum;
               ptr_in     = step_sum;
               state_in   = S_C_CHK;
            end
         end
         S_C_CHK: begin
            if (ring_rd_ff != pcount_byte) begin
               cursor_in = free_ff;
               cnt_in    = '0;
               state_in  = S_W_PREP;
            end else begin
               ring_re    = 1'b1;
               ring_raddr = ptr_inc;
               ptr_in     = ptr_inc;
               pend_re    = 1'b1;
               pend_raddr = '0;
               cnt_in     = '0;
               state_in   = S_C_CMP;
            end
         end
         S_C_CMP: begin
            if (ring_rd_ff != pend_rd_ff) begin
               cursor_in = free_ff;
               cnt_in    = '0;
               state_in  = S_W_PREP;
            end else if (cnt_next == pcount_ext) begin
               // Same as the newest record: nothing is written.
               pcount_in = '0;
               state_in  = S_IDLE;
            end else begin
               ring_re    = 1'b1;
               ring_raddr = ptr_inc;
               ptr_in     = ptr_inc;
               pend_re    = 1'b1;
               pend_raddr = cnt_next[CNT_W-1:0];
               cnt_in     = cnt_next;
               state_in   = S_C_CMP;
            end
         end
         S_W_PREP: begin
            // Fetch the pending byte and, if needed, the length of the record to evict.
            pend_re    = (cnt_ff != '0) && (cnt_ff <= pcount_ext);
            pend_raddr = cnt_dec[CNT_W-1:0];
            ring_re    = evict;
            ring_raddr = oldest_ff;
            state_in   = S_W_DO;
         end
         S_W_DO: begin
            step_base = oldest_ff;
            step_fwd  = 1'b1;
            if (evict) begin
               oldest_in = step_sum;
            end
            ring_we    = 1'b1;
            ring_waddr = free_ff;
            ring_wdata = ((cnt_ff == '0) || (cnt_ff == pcount_end)) ? pcount_byte : pend_rd_ff;
            free_in    = free_inc;
            if (cnt_ff == pcount_end) begin
               pcount_in = '0;
               state_in  = S_IDLE;
            end else begin
               cnt_in   = cnt_next;
               state_in = S_W_PREP;
            end
         end
         S_P_A: begin
            cursor_in = step_sum;
            if (after_next_ff) begin
               // The last recall was forwards, so step back one record further.
               if (step_sum == oldest_ff) begin
                  state_in = S_NF;
               end else begin
                  ring_re    = 1'b1;
                  ring_raddr = step_sum_dec;
                  ptr_in     = step_sum_dec;
                  state_in   = S_P_B;
               end
            end else begin
               ring_re    = 1'b1;
               ring_raddr = cursor_ff;
               ptr_in     = cursor_ff;
               state_in   = S_E_LEN;
            end
         end
         S_P_B: begin
            cursor_in     = step_sum;
            after_next_in = 1'b0;
            ring_re       = 1'b1;
            ring_raddr    = cursor_ff;
            ptr_in        = cursor_ff;
            state_in      = S_E_LEN;
         end
         S_N_A: begin
            step_base = cursor_ff;
            step_fwd  = 1'b1;
            if (!after_next_ff) begin
               if (step_sum == free_ff) begin
                  state_in = S_NF;
               end else begin
                  cursor_in  = step_sum;
                  ring_re    = 1'b1;
                  ring_raddr = step_sum;
                  state_in   = S_N_B;
               end
            end else begin
               after_next_in = 1'b0;
               if (step_sum == free_ff) begin
                  state_in = S_NF;
               end else begin
                  after_next_in = 1'b1;
                  cursor_in     = step_sum;
                  ring_re       = 1'b1;
                  ring_raddr    = step_sum;
                  ptr_in        = step_sum;
                  state_in      = S_E_LEN;
               end
            end
         end
         S_N_B: begin
            step_base     = cursor_ff;
            step_fwd      = 1'b1;
            after_next_in = 1'b0;
            if (step_sum == free_ff) begin
               state_in = S_NF;
            end else begin
               after_next_in = 1'b1;
               cursor_in     = step_sum;
               ring_re       = 1'b1;
               ring_raddr    = step_sum;
               ptr_in        = step_sum;
               state_in      = S_E_LEN;
            end
         end
         S_E_LEN: begin
            // A zero length is the empty sentinel record.
            if (ring_rd_ff == 8'd0) begin
               state_in = S_NF;
            end else begin
               len_in     = (ring_rd_ff > 8'(MAX_CMD_LEN)) ? CNT_W'(MAX_CMD_LEN)
                                                           : ring_rd_ff[CNT_W-1:0];
               ring_re    = 1'b1;
               ring_raddr = ptr_inc;
               ptr_in     = ptr_inc;
               cnt_in     = '0;
               state_in   = S_E_BYTE;
            end
         end
         S_E_BYTE: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_byte_in = ring_rd_ff;
               found_in    = 1'b1;
               last_in     = (cnt_next == len_ext);
               if (cnt_next == len_ext) begin
                  state_in = S_IDLE;
               end else begin
                  ring_re    = 1'b1;
                  ring_raddr = ptr_inc;
                  ptr_in     = ptr_inc;
                  cnt_in     = cnt_next;
               end
            end
         end
         S_NF: begin
            if (out_free) begin
               out_load = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT0;
         oldest_ff     <= '0;
         cursor_ff     <= '0;
         free_ff       <= PTR_W'(2);
         after_next_ff <= 1'b0;
         pcount_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         cursor_ff     <= cursor_in;
         free_ff       <= free_in;
         after_next_ff <= after_next_in;
         pcount_ff     <= pcount_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the response payload.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      len_ff <= len_in;
      if (out_load) begin
         out_byte_ff <= out_byte_in;
         found_ff    <= found_in;
         last_ff     <= last_in;
      end
   end

   // Byte store: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[ring_raddr];
      end
   end

   // Pending command buffer.
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pcount_ff] <= req_chan.in_byte;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[pend_raddr];
      end
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.last     = last_ff;

endmodule
